@@ rtl/psts_pkg.sv @@
// ----------------------------------------------------------------------------
// psts_pkg: shared types and constants for position snap to surface
// Beat structs, status and register codes, pipeline depths.
// ----------------------------------------------------------------------------
package psts_pkg;

    localparam int SQRT_STAGES = 32;   // one result bit per stage
    localparam int DIV_STAGES  = 31;   // quotient never exceeds the 31-bit radius
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_Y_NONZERO  = 2'd1;
    localparam logic [1:0] ST_OUT_BOUNDS = 2'd2;
    localparam logic [1:0] ST_OFF_SPHERE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FLAT_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_EXT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_TOL   = 2'd3;

    localparam logic OP_CHECK = 1'b0;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } out_beat_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return m;
    endfunction

    function automatic logic [63:0] sqrt_bit(input int k);
        logic [63:0] b;
        b = 64'd1 << (62 - 2 * k);
        return b;
    endfunction

endpackage

@@ rtl/psts_sqrt.sv @@
// ----------------------------------------------------------------------------
// psts_sqrt: pipelined integer square root
// floor(sqrt) of a 64-bit value, one bit pair per stage.
// ----------------------------------------------------------------------------
module psts_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] rad_in,
    output logic [31:0] len_out
);

    logic [63:0] v_reg [psts_pkg::SQRT_STAGES];
    logic [63:0] r_reg [psts_pkg::SQRT_STAGES];
    logic [63:0] v_next [psts_pkg::SQRT_STAGES];
    logic [63:0] r_next [psts_pkg::SQRT_STAGES];

    always_comb begin
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] t;
        for (int k = 0; k < psts_pkg::SQRT_STAGES; k++) begin
            v = (k == 0) ? rad_in : v_reg[k-1];
            r = (k == 0) ? 64'd0 : r_reg[k-1];
            t = r + psts_pkg::sqrt_bit(k);
            if (v >= t) begin
                v_next[k] = v - t;
                r_next[k] = (r >> 1) + psts_pkg::sqrt_bit(k);
            end else begin
                v_next[k] = v;
                r_next[k] = r >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < psts_pkg::SQRT_STAGES; k++) begin
                v_reg[k] <= v_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign len_out = r_reg[psts_pkg::SQRT_STAGES-1][31:0];

endmodule

@@ rtl/psts_div.sv @@
// ----------------------------------------------------------------------------
// psts_div: pipelined restoring divider
// 64-bit numerator by 32-bit divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module psts_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [63:0]                       num_in,
    input  logic [31:0]                       den_in,
    output logic [psts_pkg::DIV_STAGES-1:0]   quo_out
);

    localparam int N = psts_pkg::DIV_STAGES;

    logic [63:0]  rem_reg  [N];
    logic [31:0]  den_reg  [N];
    logic [N-1:0] quo_reg  [N];
    logic [63:0]  rem_next [N];
    logic [N-1:0] quo_next [N];

    always_comb begin
        logic [63:0]  rem;
        logic [31:0]  den;
        logic [N-1:0] quo;
        logic [63:0]  dsh;
        for (int i = 0; i < N; i++) begin
            rem = (i == 0) ? num_in : rem_reg[i-1];
            den = (i == 0) ? den_in : den_reg[i-1];
            quo = (i == 0) ? '0 : quo_reg[i-1];
            dsh = {32'd0, den} << (N - 1 - i);
            if (rem >= dsh) begin
                rem_next[i] = rem - dsh;
                quo_next[i] = quo | (N'(1) << (N - 1 - i));
            end else begin
                rem_next[i] = rem;
                quo_next[i] = quo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= (i == 0) ? den_in : den_reg[i-1];
            end
        end
    end

    assign quo_out = quo_reg[N-1];

endmodule

@@ rtl/position_snap_to_surface_core.sv @@
// ----------------------------------------------------------------------------
// position_snap_to_surface_core: snap or place a point on a plane or sphere
// Flat: bound checks and clamping. Sphere: length by square root, then
// radial projection by three dividers.
// ----------------------------------------------------------------------------
// channel | ports               | beat
// --------+---------------------+------------------------------------------
// input   | s_valid s_ready     | s_data: operation, pos_x, pos_y, pos_z
// result  | m_valid m_ready     | m_data: status, out_x, out_y, out_z
// config  | cfg_wr_en cfg_index | cfg_wdata, taken on any enabled edge
//
// One beat per cycle in and out while the result is taken; the depth is set
// by the bit-per-stage root and divider pipelines.
// Reset clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; s_ready drops with it, so
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module position_snap_to_surface_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  psts_pkg::in_beat_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output psts_pkg::out_beat_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [psts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int SQ = psts_pkg::SQRT_STAGES;
    localparam int DV = psts_pkg::DIV_STAGES;

    // beat carried across the divider stages
    typedef struct packed {
        psts_pkg::in_beat_t item;
        logic [1:0]         st;
        logic               lz;
    } mid_t;

    // configuration registers
    logic        flat_mode_reg;
    logic [30:0] radius_reg;
    logic [30:0] half_ext_reg;
    logic [30:0] snap_tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flat_mode_reg <= 1'b1;
            radius_reg    <= 31'd6553600;
            half_ext_reg  <= 31'd3276800;
            snap_tol_reg  <= 31'd32768;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                psts_pkg::REG_FLAT_MODE: flat_mode_reg <= cfg_wdata[0];
                psts_pkg::REG_RADIUS:    radius_reg    <= cfg_wdata;
                psts_pkg::REG_HALF_EXT:  half_ext_reg  <= cfg_wdata;
                psts_pkg::REG_SNAP_TOL:  snap_tol_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: the whole pipe moves unless the result is held
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 0: input register
    logic               v0_reg;
    psts_pkg::in_beat_t i0_reg;
    // stage 1: squares
    logic               v1_reg;
    psts_pkg::in_beat_t i1_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg;
    // stage 2: sum of squares
    logic               v2_reg;
    psts_pkg::in_beat_t i2_reg;
    logic [63:0]        sum_reg;
    // root stages: side line alongside the sqrt unit
    logic               vsq_reg [SQ];
    psts_pkg::in_beat_t isq_reg [SQ];
    logic [31:0]        len;
    // stage 3: status and numerators
    logic               v3_reg;
    mid_t               m3_reg;
    logic [63:0]        nx_reg, ny_reg, nz_reg;
    logic [31:0]        len3_reg;
    // divider stages: side line
    logic               vdv_reg [DV];
    mid_t               mdv_reg [DV];
    logic [DV-1:0]      qx, qy, qz;
    // output register
    logic               vo_reg;
    psts_pkg::out_beat_t o_reg;
    psts_pkg::out_beat_t o_next;

    // stage 3 next values
    mid_t        m3_next;
    logic [63:0] nx_next, ny_next, nz_next;

    always_comb begin
        logic [31:0] diff;
        logic [31:0] r32;
        r32  = {1'b0, radius_reg};
        diff = (len > r32) ? (len - r32) : (r32 - len);
        m3_next.item = isq_reg[SQ-1];
        m3_next.lz   = (len == 32'd0);
        m3_next.st   = psts_pkg::ST_OK;
        if (isq_reg[SQ-1].operation == psts_pkg::OP_CHECK &&
            diff > {1'b0, snap_tol_reg}) begin
            m3_next.st = psts_pkg::ST_OFF_SPHERE;
        end
        nx_next = 64'(psts_pkg::mag32(isq_reg[SQ-1].pos_x)) * 64'(radius_reg) + 64'(len >> 1);
        ny_next = 64'(psts_pkg::mag32(isq_reg[SQ-1].pos_y)) * 64'(radius_reg) + 64'(len >> 1);
        nz_next = 64'(psts_pkg::mag32(isq_reg[SQ-1].pos_z)) * 64'(radius_reg) + 64'(len >> 1);
    end

    // final stage: flat handling and sphere result selection
    always_comb begin
        psts_pkg::in_beat_t it;
        logic signed [32:0] h;
        logic signed [32:0] x33;
        logic signed [32:0] z33;
        it  = mdv_reg[DV-1].item;
        h   = {2'b00, half_ext_reg};
        x33 = 33'(it.pos_x);
        z33 = 33'(it.pos_z);
        o_next.status = psts_pkg::ST_OK;
        o_next.out_x  = it.pos_x;
        o_next.out_y  = it.pos_y;
        o_next.out_z  = it.pos_z;
        if (flat_mode_reg) begin
            if (it.operation == psts_pkg::OP_CHECK) begin
                if (it.pos_y != 32'sd0) begin
                    o_next.status = psts_pkg::ST_Y_NONZERO;
                end else if (x33 > h || x33 < -h || z33 > h || z33 < -h) begin
                    o_next.status = psts_pkg::ST_OUT_BOUNDS;
                end
            end else begin
                o_next.out_y = 32'sd0;
                if (x33 > h)       o_next.out_x = 32'(h);
                else if (x33 < -h) o_next.out_x = 32'(-h);
                if (z33 > h)       o_next.out_z = 32'(h);
                else if (z33 < -h) o_next.out_z = 32'(-h);
            end
        end else if (mdv_reg[DV-1].st == psts_pkg::ST_OFF_SPHERE) begin
            o_next.status = psts_pkg::ST_OFF_SPHERE;
        end else if (mdv_reg[DV-1].lz) begin
            // zero vector lands on the south pole
            o_next.out_x = 32'sd0;
            o_next.out_y = 32'sd0;
            o_next.out_z = -$signed({1'b0, radius_reg});
        end else begin
            o_next.out_x = it.pos_x[31] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            o_next.out_y = it.pos_y[31] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            o_next.out_z = it.pos_z[31] ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
        end
    end

    psts_sqrt u_sqrt (
        .aclk    (aclk),
        .en      (en),
        .rad_in  (sum_reg),
        .len_out (len)
    );

    psts_div u_div_x (.aclk(aclk), .en(en), .num_in(nx_reg), .den_in(len3_reg), .quo_out(qx));
    psts_div u_div_y (.aclk(aclk), .en(en), .num_in(ny_reg), .den_in(len3_reg), .quo_out(qy));
    psts_div u_div_z (.aclk(aclk), .en(en), .num_in(nz_reg), .den_in(len3_reg), .quo_out(qz));

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k < SQ; k++) vsq_reg[k] <= 1'b0;
            for (int k = 0; k < DV; k++) vdv_reg[k] <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            for (int k = 0; k < SQ; k++) vsq_reg[k] <= (k == 0) ? v2_reg : vsq_reg[k-1];
            v3_reg <= vsq_reg[SQ-1];
            for (int k = 0; k < DV; k++) vdv_reg[k] <= (k == 0) ? v3_reg : vdv_reg[k-1];
            vo_reg <= vdv_reg[DV-1];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            i0_reg  <= s_data;
            i1_reg  <= i0_reg;
            sqx_reg <= 64'(psts_pkg::mag32(i0_reg.pos_x)) * 64'(psts_pkg::mag32(i0_reg.pos_x));
            sqy_reg <= 64'(psts_pkg::mag32(i0_reg.pos_y)) * 64'(psts_pkg::mag32(i0_reg.pos_y));
            sqz_reg <= 64'(psts_pkg::mag32(i0_reg.pos_z)) * 64'(psts_pkg::mag32(i0_reg.pos_z));
            i2_reg  <= i1_reg;
            sum_reg <= sqx_reg + sqy_reg + sqz_reg;
            for (int k = 0; k < SQ; k++) isq_reg[k] <= (k == 0) ? i2_reg : isq_reg[k-1];
            m3_reg   <= m3_next;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            nz_reg   <= nz_next;
            len3_reg <= len;
            for (int k = 0; k < DV; k++) mdv_reg[k] <= (k == 0) ? m3_reg : mdv_reg[k-1];
            o_reg <= o_next;
        end
    end

    assign m_valid = vo_reg;
    assign m_data  = o_reg;

`ifndef SYNTHESIS
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v3_reg) && $stable(vo_reg))
        else $error("pipeline moved while stalled");
    a_flat_no_sphere: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == psts_pkg::ST_OFF_SPHERE |-> !flat_mode_reg)
        else $error("off-sphere status in flat mode");
    a_flat_ok_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && flat_mode_reg && m_data.status == psts_pkg::ST_OK |-> m_data.out_y == 32'sd0)
        else $error("flat result off the plane");
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result beat straight after reset");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: position snap to surface core
// A directed table of beats, then random phases over a range of register
// settings and handshake pressure. Every result is checked, field by field,
// against a hand-written value or an in-bench model of the flat and sphere snap/place behaviour.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_PLACE = ~psts_pkg::OP_CHECK;
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
    localparam int SETTLE = 5 + psts_pkg::SQRT_STAGES + psts_pkg::DIV_STAGES + 12;

    typedef struct {
        bit                  flat;    // surface the row runs against (other regs at reset)
        psts_pkg::in_beat_t  beat;
        bit                  known;   // want holds a hand-written result
        psts_pkg::out_beat_t want;
    } row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    psts_pkg::in_beat_t  s_data;
    logic                m_valid;
    logic                m_ready;
    psts_pkg::out_beat_t m_data;
    logic                cfg_wr_en;
    logic [psts_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [psts_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // bench copy of the registers
    bit          cur_flat;
    logic [30:0] cur_radius;
    logic [30:0] cur_half;
    logic [30:0] cur_tol;

    psts_pkg::out_beat_t pending_q[$];   // results owed by the core, oldest first
    int        errors;
    int        idle_pct;
    int        stall_pct;

    position_snap_to_surface_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---- model -------------------------------------------------------------

    // floor square root of a 64-bit value
    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // c * radius / len, nearest, ties away from zero
    function automatic logic [31:0] radial(longint c, longint unsigned len,
                                           longint unsigned r);
        longint unsigned m;
        longint unsigned q;
        m = (c < 0) ? longint'(-c) : longint'(c);
        q = (m * r + len / 2) / len;
        return (c < 0) ? 32'(-longint'(q)) : 32'(q);
    endfunction

    function automatic logic [31:0] clamp_to(longint v, longint lim);
        if (v > lim)  return 32'(lim);
        if (v < -lim) return 32'(-lim);
        return 32'(v);
    endfunction

    function automatic psts_pkg::out_beat_t snap_predict(psts_pkg::in_beat_t b);
        longint x, y, z, h;
        longint unsigned ax, ay, az, len, r, diff;
        psts_pkg::out_beat_t o;
        bit proj;
        x  = b.pos_x;
        y  = b.pos_y;
        z  = b.pos_z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        o.status = psts_pkg::ST_OK;
        o.out_x  = b.pos_x;
        o.out_y  = b.pos_y;
        o.out_z  = b.pos_z;
        if (cur_flat) begin
            h = longint'(cur_half);
            if (b.operation == psts_pkg::OP_CHECK) begin
                // y is tested first
                if (y != 0)
                    o.status = psts_pkg::ST_Y_NONZERO;
                else if (ax > h || az > h)
                    o.status = psts_pkg::ST_OUT_BOUNDS;
            end else begin
                o.out_x = clamp_to(x, h);
                o.out_y = '0;
                o.out_z = clamp_to(z, h);
            end
        end else begin
            len  = root64(ax * ax + ay * ay + az * az);
            r    = cur_radius;
            proj = 1'b1;
            if (b.operation == psts_pkg::OP_CHECK) begin
                diff = (len > r) ? len - r : r - len;
                if (diff > cur_tol) begin
                    o.status = psts_pkg::ST_OFF_SPHERE;
                    proj     = 1'b0;
                end
            end
            if (proj) begin
                if (len == 0) begin
                    // zero vector goes to the south pole
                    o.out_x = '0;
                    o.out_y = '0;
                    o.out_z = 32'(-longint'(r));
                end else begin
                    o.out_x = radial(x, len, r);
                    o.out_y = radial(y, len, r);
                    o.out_z = radial(z, len, r);
                end
            end
        end
        return o;
    endfunction

    // ---- result side -------------------------------------------------------

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        psts_pkg::out_beat_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected: %h", m_data);
                errors++;
            end else begin
                w = pending_q.pop_front();
                if (m_data.status !== w.status) begin
                    $error("status: expected %0d, got %0d", w.status, m_data.status);
                    errors++;
                end
                if (m_data.out_x !== w.out_x) begin
                    $error("out_x: expected %0d, got %0d", w.out_x, m_data.out_x);
                    errors++;
                end
                if (m_data.out_y !== w.out_y) begin
                    $error("out_y: expected %0d, got %0d", w.out_y, m_data.out_y);
                    errors++;
                end
                if (m_data.out_z !== w.out_z) begin
                    $error("out_z: expected %0d, got %0d", w.out_z, m_data.out_z);
                    errors++;
                end
            end
        end
    end

    // ---- input side --------------------------------------------------------

    // Offer one beat, with random gaps first; the expectation is queued on
    // the accepting edge. Valid is only lowered in a gap, never re-raised in
    // the same step.
    task automatic push_beat(psts_pkg::in_beat_t b, psts_pkg::out_beat_t want);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        pending_q.push_back(want);
    endtask

    // Hold the input off until every owed result is back, then let the
    // pipeline empty out.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic reg_write(logic [psts_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // all four registers, core idle
    task automatic set_regs(bit flat, logic [30:0] r, logic [30:0] h, logic [30:0] t);
        reg_write(psts_pkg::REG_FLAT_MODE, {30'd0, flat});
        reg_write(psts_pkg::REG_RADIUS, r);
        reg_write(psts_pkg::REG_HALF_EXT, h);
        reg_write(psts_pkg::REG_SNAP_TOL, t);
        cfg_wr_en  <= 1'b0;
        cur_flat   = flat;
        cur_radius = r;
        cur_half   = h;
        cur_tol    = t;
    endtask

    function automatic row_t mk_row(bit flat, logic op, int x, int y, int z, bit known,
                                    logic [1:0] st, int ox, int oy, int oz);
        row_t rw;
        rw.flat = flat;
        rw.beat = '{operation: op, pos_x: x, pos_y: y, pos_z: z};
        rw.known = known;
        rw.want = '{status: st, out_x: ox, out_y: oy, out_z: oz};
        return rw;
    endfunction

    // Mostly well-formed points near the surface, some raw noise.
    function automatic psts_pkg::in_beat_t random_point();
        psts_pkg::in_beat_t b;
        int kind;
        longint h, dx, dy, dz, n;
        longint unsigned len;
        kind = $urandom_range(9);
        b.operation = $urandom_range(1);
        b.pos_x = $urandom;
        b.pos_y = $urandom;
        b.pos_z = $urandom;
        if (kind < 2) begin
            // full-range noise
        end else if (kind < 4) begin
            b.pos_x = $signed($urandom_range(0, 2000)) - 1000;
            b.pos_y = $signed($urandom_range(0, 2000)) - 1000;
            b.pos_z = $signed($urandom_range(0, 2000)) - 1000;
        end else if (cur_flat) begin
            h = longint'(cur_half) + 2;
            dx = longint'({$urandom, $urandom} % (2 * h + 1)) - h;
            dz = longint'({$urandom, $urandom} % (2 * h + 1)) - h;
            b.pos_x = 32'(dx);
            b.pos_z = 32'(dz);
            b.pos_y = (kind < 9) ? 32'd0 : 32'($urandom_range(0, 4)) - 2;
        end else begin
            // a direction scaled onto the sphere, nudged by a little noise
            dx = longint'($urandom_range(0, 2000)) - 1000;
            dy = longint'($urandom_range(0, 2000)) - 1000;
            dz = longint'($urandom_range(0, 2000)) - 1000;
            len = root64(dx * dx + dy * dy + dz * dz);
            if (len != 0) begin
                n = (cur_tol > 31'd1048576) ? 1048576 : longint'(cur_tol) + 2;
                b.pos_x = 32'(dx * longint'(cur_radius) / longint'(len)
                              + longint'({$urandom, $urandom} % (2 * n + 1)) - n);
                b.pos_y = 32'(dy * longint'(cur_radius) / longint'(len));
                b.pos_z = 32'(dz * longint'(cur_radius) / longint'(len));
            end
        end
        return b;
    endfunction

    // ---- main sequence -----------------------------------------------------

    initial begin
        row_t rows[$];
        psts_pkg::out_beat_t want;
        psts_pkg::in_beat_t b;
        logic [30:0] ph[0:9][0:2];
        bit ph_flat[0:9];
        int idle_set[0:3][0:1];

        errors    = 0;
        idle_pct  = 0;
        stall_pct = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cur_flat   = 1'b1;
        cur_radius = 31'd6553600;
        cur_half   = 31'd3276800;
        cur_tol    = 31'd32768;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: flat rows run on the reset defaults, sphere rows only
        // flip the mode
        rows.push_back(mk_row(1, psts_pkg::OP_CHECK, 0, 0, 0, 1, psts_pkg::ST_OK, 0, 0, 0));
        rows.push_back(mk_row(1, psts_pkg::OP_CHECK, 3276800, 0, -3276800, 1, psts_pkg::ST_OK,
                              3276800, 0, -3276800));
        rows.push_back(mk_row(1, psts_pkg::OP_CHECK, 5, 1, 5, 1, psts_pkg::ST_Y_NONZERO,
                              5, 1, 5));
        rows.push_back(mk_row(1, psts_pkg::OP_CHECK, 3276801, 0, 0, 1,
                              psts_pkg::ST_OUT_BOUNDS, 3276801, 0, 0));
        rows.push_back(mk_row(1, psts_pkg::OP_CHECK, 0, 0, -3276801, 1,
                              psts_pkg::ST_OUT_BOUNDS, 0, 0, -3276801));
        // y wins over the bounds
        rows.push_back(mk_row(1, psts_pkg::OP_CHECK, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, 1, psts_pkg::ST_Y_NONZERO, 32'h8000_0000,
                              32'h7FFF_FFFF, 32'h8000_0000));
        rows.push_back(mk_row(1, OP_PLACE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                              1, psts_pkg::ST_OK, 3276800, 0, -3276800));
        rows.push_back(mk_row(1, OP_PLACE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                              1, psts_pkg::ST_OK, -3276800, 0, 3276800));
        rows.push_back(mk_row(1, OP_PLACE, 12, -7, -9, 1, psts_pkg::ST_OK, 12, 0, -9));
        rows.push_back(mk_row(0, OP_PLACE, 0, 0, 0, 1, psts_pkg::ST_OK, 0, 0, -6553600));
        rows.push_back(mk_row(0, psts_pkg::OP_CHECK, 0, 0, 0, 1, psts_pkg::ST_OFF_SPHERE,
                              0, 0, 0));
        rows.push_back(mk_row(0, psts_pkg::OP_CHECK, 6553600, 0, 0, 1, psts_pkg::ST_OK,
                              6553600, 0, 0));
        rows.push_back(mk_row(0, psts_pkg::OP_CHECK, 1, 1, 1, 1, psts_pkg::ST_OFF_SPHERE,
                              1, 1, 1));
        rows.push_back(mk_row(0, psts_pkg::OP_CHECK, 6586369, 0, 0, 1,
                              psts_pkg::ST_OFF_SPHERE, 6586369, 0, 0));
        rows.push_back(mk_row(0, psts_pkg::OP_CHECK, 0, -6586368, 0, 0, psts_pkg::ST_OK,
                              0, 0, 0));
        rows.push_back(mk_row(0, psts_pkg::OP_CHECK, 6520832, 0, 0, 0, psts_pkg::ST_OK,
                              0, 0, 0));
        rows.push_back(mk_row(0, OP_PLACE, -7, 3, 100, 0, psts_pkg::ST_OK, 0, 0, 0));
        rows.push_back(mk_row(0, OP_PLACE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              0, psts_pkg::ST_OK, 0, 0, 0));
        rows.push_back(mk_row(0, OP_PLACE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              0, psts_pkg::ST_OK, 0, 0, 0));
        rows.push_back(mk_row(0, OP_PLACE, 32'h8000_0000, 0, 1, 0, psts_pkg::ST_OK,
                              0, 0, 0));
        rows.push_back(mk_row(0, psts_pkg::OP_CHECK, 3000000, -4000000, 3800000, 0,
                              psts_pkg::ST_OK, 0, 0, 0));

        foreach (rows[i]) begin
            if (rows[i].flat != cur_flat) begin
                drain();
                set_regs(rows[i].flat, cur_radius, cur_half, cur_tol);
            end
            want = rows[i].known ? rows[i].want : snap_predict(rows[i].beat);
            push_beat(rows[i].beat, want);
        end

        // register settings per phase: radius, half extent, tolerance
        ph_flat[0] = 1; ph[0] = '{31'd6553600, 31'd3276800, 31'd32768};
        ph_flat[1] = 0; ph[1] = '{31'd6553600, 31'd3276800, 31'd32768};
        ph_flat[2] = 1; ph[2] = '{31'd1, 31'd0, 31'd0};
        ph_flat[3] = 0; ph[3] = '{31'd1, 31'd0, 31'd0};
        ph_flat[4] = 1; ph[4] = '{31'd1, MAX31, MAX31};
        ph_flat[5] = 0; ph[5] = '{MAX31, 31'd0, 31'd0};
        ph_flat[6] = 0; ph[6] = '{MAX31, MAX31, MAX31};
        ph_flat[7] = 0; ph[7] = '{31'd65536, 31'd65536, 31'd65536};
        ph_flat[8] = 1; ph[8] = '{31'd65536, 31'd1000, 31'd7};
        ph_flat[9] = 0; ph[9] = '{31'd40000000, 31'd12345, 31'd300};

        idle_set = '{'{0, 0}, '{70, 0}, '{0, 70}, '{18, 18}};

        for (int p = 0; p < 12; p++) begin
            drain();
            if (p < 10)
                set_regs(ph_flat[p], ph[p][0], ph[p][1], ph[p][2]);
            else
                set_regs($urandom_range(1), 31'($urandom_range(1, 2147483647)),
                         31'($urandom), 31'($urandom_range(0, 1 << 20)));
            for (int k = 0; k < 135; k++) begin
                idle_pct  = idle_set[(k / 34) % 4][0];
                stall_pct = idle_set[(k / 34) % 4][1];
                // a mid-phase pause until the core has emptied
                if (k == 70) begin
                    s_valid <= 1'b0;
                    while (pending_q.size() != 0) @(posedge aclk);
                end
                b = random_point();
                push_beat(b, snap_predict(b));
            end
        end

        s_valid   <= 1'b0;
        stall_pct = 0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

endmodule
